@@ src/wdce_pkg.sv @@
// Shared types and constants for the WAV data chunk extractor.
package wdce_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int HOLD_DEPTH        = 12;
    localparam int HOLD_AW           = 4;
    localparam int JOBQ_ENTRIES      = 4;
    localparam int RELEASE_POS       = 43;
    localparam int RIFF_END_POS      = 3;
    localparam int WAVE_END_POS      = 11;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

    localparam logic [32:0] CHUNK_HDR_LEN = 33'd8;
    localparam logic [32:0] TAG_BYTES_LEFT = 33'd4;

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
    localparam logic [2:0] PH_SKIP      = 3'd2;
    localparam logic [2:0] PH_DATA      = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;
    localparam logic [2:0] PH_BAD       = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NO_DATA = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // one entry of work handed from the parser to the output side
    typedef struct packed {
        logic               hold_wr;
        logic [HOLD_AW-1:0] hold_addr;
        logic [HOLD_AW-1:0] rel_cnt;
        logic               smp_v;
        logic [15:0]        smp;
        logic               st_v;
        logic [1:0]         status;
        logic [30:0]        total;
    } t_job;

endpackage

@@ src/wav_data_chunk_extractor.sv @@
// Top level of the WAV data chunk extractor: parser, job queue and output side.
//
// Input stream: one byte of a RIFF/WAVE file image per word on s_axis, tlast on
// the final byte of the file. The header (RIFF at bytes 0-3, WAVE at 8-11) is
// checked, chunks are walked by size, and the first data chunk is returned as
// signed 16-bit little-endian samples on m_axis (tuser 0). On the final byte a
// status word follows (tuser 1) carrying ok / invalid header / no data chunk and
// the number of samples delivered; the parser then starts afresh for a new file.
// m_axis tlast marks the last result word caused by one input byte.
// Throughput: one input byte per cycle. Each byte gives at most one sample and
// one status word; at byte 43 the samples held from earlier bytes (up to 12)
// are released one per cycle by the output side while m_axis_tready is high,
// the four-entry job queue soaks this up and s_axis_tready drops only when
// the queue is full. With the queue empty a result word passes through the
// queue entry and then the output register after its byte is taken.
// Reset (i_rst_n low, synchronous) clears the parser, queue and output valid.
// A stall on m_axis_tready holds the output word; the parser keeps taking bytes
// until the queue fills.
module wav_data_chunk_extractor import wdce_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] pcm_sample, [17:16] parse_status,
                                        // [48:18] sample_total, [55:49] zero
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast
);

    logic push;
    t_job push_job;
    logic full;
    logic pop;
    t_job head;
    logic empty;

    wdce_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .i_byte (s_axis_tdata),
        .i_eof  (s_axis_tlast),
        .o_ready(s_axis_tready),
        .o_push (push),
        .o_job  (push_job),
        .i_full (full)
    );

    wdce_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (full),
        .i_pop  (pop),
        .o_head (head),
        .o_empty(empty)
    );

    wdce_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (head),
        .i_empty(empty),
        .o_pop  (pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (m_axis_tdata),
        .o_kind (m_axis_tuser),
        .o_last (m_axis_tlast)
    );

endmodule

@@ src/wdce_front.sv @@
// Byte parser: walks the RIFF chunks and turns each byte into a job for the output side.
module wdce_front import wdce_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eof,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job,
    input  logic       i_full
);

    localparam logic [POSITION_BITS-1:0] POS_REL  = POSITION_BITS'(RELEASE_POS);
    localparam logic [POSITION_BITS-1:0] POS_RIFF = POSITION_BITS'(RIFF_END_POS);
    localparam logic [POSITION_BITS-1:0] POS_WAVE = POSITION_BITS'(WAVE_END_POS);

    logic [2:0]               r_phase, n_phase;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [31:0]              r_tag, n_tag;
    logic [31:0]              r_size, n_size;
    logic [32:0]              r_skip, n_skip;
    logic [31:0]              r_drem, n_drem;
    logic [8:0]               r_pend, n_pend;
    logic [HOLD_AW-1:0]       r_hcnt, n_hcnt;
    logic [30:0]              r_dcnt, n_dcnt;

    logic        acc;
    logic        rel;
    logic [31:0] d_sum;
    logic [30:0] d_rel;
    logic [32:0] sk_dec;
    logic [32:0] sk_new;
    logic [31:0] dr_dec;
    logic [15:0] smp;
    logic        hold_wr;
    logic        smp_v;
    logic [1:0]  status;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;

    always_comb begin
        rel     = (r_pos == POS_REL) && (r_phase != PH_BAD);
        d_sum   = {1'b0, r_dcnt} + {28'd0, (rel ? r_hcnt : HOLD_AW'(0))};
        d_rel   = d_sum[31] ? COUNT_MAX : d_sum[30:0];
        sk_dec  = (r_skip != 33'd0) ? r_skip - 33'd1 : r_skip;
        dr_dec  = (r_drem != 32'd0) ? r_drem - 32'd1 : r_drem;
        smp     = {i_byte, r_pend[7:0]};
        sk_new  = 33'd0;
        hold_wr = 1'b0;
        smp_v   = 1'b0;
        status  = ST_OK;

        n_phase = r_phase;
        n_tag   = r_tag;
        n_size  = r_size;
        n_skip  = r_skip;
        n_drem  = r_drem;
        n_pend  = r_pend;
        n_hcnt  = rel ? HOLD_AW'(0) : r_hcnt;
        n_dcnt  = d_rel;
        n_pos   = (r_pos != '1) ? r_pos + POSITION_BITS'(1) : r_pos;

        case (r_phase)
            PH_HEADER: begin
                n_tag = {r_tag[23:0], i_byte};
                if (r_pos == POS_RIFF && n_tag != TAG_RIFF) begin
                    n_phase = PH_BAD;
                end else if (r_pos == POS_WAVE) begin
                    if (n_tag != TAG_WAVE) begin
                        n_phase = PH_BAD;
                    end else begin
                        n_phase = PH_CHUNK_HDR;
                        n_skip  = CHUNK_HDR_LEN;
                    end
                end
            end
            PH_CHUNK_HDR: begin
                if (r_skip > TAG_BYTES_LEFT) begin
                    n_tag = {r_tag[23:0], i_byte};
                end else begin
                    n_size = {i_byte, r_size[31:8]};
                end
                n_skip = sk_dec;
                sk_new = {1'b0, n_size} + {32'd0, n_size[0]};
                if (sk_dec == 33'd0 && !i_eof) begin
                    if (n_tag == TAG_DATA) begin
                        n_drem  = n_size;
                        n_pend  = 9'd0;
                        n_phase = (n_size != 32'd0) ? PH_DATA : PH_DONE;
                    end else if (sk_new == 33'd0) begin
                        n_skip = CHUNK_HDR_LEN;
                    end else begin
                        n_skip  = sk_new;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = sk_dec;
                if (sk_dec == 33'd0) begin
                    n_phase = PH_CHUNK_HDR;
                    n_skip  = CHUNK_HDR_LEN;
                end
            end
            PH_DATA: begin
                if (r_pend[8]) begin
                    n_pend = 9'd0;
                    if (r_pos < POS_REL) begin
                        if (r_hcnt < HOLD_AW'(HOLD_DEPTH)) begin
                            hold_wr = 1'b1;
                            n_hcnt  = r_hcnt + HOLD_AW'(1);
                        end
                    end else begin
                        smp_v = 1'b1;
                        if (d_rel != COUNT_MAX) begin
                            n_dcnt = d_rel + 31'd1;
                        end
                    end
                end else begin
                    n_pend = {1'b1, i_byte};
                end
                n_drem = dr_dec;
                if (dr_dec == 32'd0) begin
                    n_phase = PH_DONE;
                    n_pend  = 9'd0;
                end
            end
            default: begin
            end
        endcase

        if (r_pos < POS_REL || n_phase == PH_BAD) begin
            status = ST_INVALID;
        end else if (n_phase == PH_DATA || n_phase == PH_DONE) begin
            status = ST_OK;
        end else begin
            status = ST_NO_DATA;
        end

        // held samples are dropped when the file ends early
        o_job.hold_wr   = hold_wr && !i_eof;
        o_job.hold_addr = r_hcnt;
        o_job.rel_cnt   = rel ? r_hcnt : HOLD_AW'(0);
        o_job.smp_v     = smp_v;
        o_job.smp       = smp;
        o_job.st_v      = i_eof;
        o_job.status    = status;
        o_job.total     = (status == ST_INVALID) ? 31'd0 : n_dcnt;

        o_push = acc && (o_job.hold_wr || o_job.rel_cnt != HOLD_AW'(0) ||
                         smp_v || i_eof);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_tag   <= '0;
            r_size  <= '0;
            r_skip  <= '0;
            r_drem  <= '0;
            r_pend  <= '0;
            r_hcnt  <= '0;
            r_dcnt  <= '0;
        end else if (acc) begin
            if (i_eof) begin
                r_phase <= PH_HEADER;
                r_pos   <= '0;
                r_tag   <= '0;
                r_size  <= '0;
                r_skip  <= '0;
                r_drem  <= '0;
                r_pend  <= '0;
                r_hcnt  <= '0;
                r_dcnt  <= '0;
            end else begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_tag   <= n_tag;
                r_size  <= n_size;
                r_skip  <= n_skip;
                r_drem  <= n_drem;
                r_pend  <= n_pend;
                r_hcnt  <= n_hcnt;
                r_dcnt  <= n_dcnt;
            end
        end
    end

endmodule

@@ src/wdce_queue.sv @@
// Short job queue between the parser and the output side.
module wdce_queue import wdce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);

    localparam int PW = $clog2(JOBQ_ENTRIES);

    t_job          r_mem [JOBQ_ENTRIES];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(JOBQ_ENTRIES));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/wdce_back.sv @@
// Output side: keeps early samples, then emits one result word per cycle while i_ready allows.
module wdce_back import wdce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [55:0] o_data,
    output logic        o_kind,
    output logic        o_last
);

    logic [15:0]        r_hold [HOLD_DEPTH];
    logic [HOLD_AW-1:0] r_rel_idx;
    logic               r_smp_done;
    logic               r_out_valid;
    logic [55:0]        r_out_data;
    logic               r_out_kind;
    logic               r_out_last;

    logic        out_free;
    logic        wr_job;
    logic        emit;
    logic        rel_now;
    logic        smp_now;
    logic        last;
    logic [55:0] data;
    logic        kind;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        wr_job   = !i_empty && i_head.hold_wr;
        emit     = !i_empty && !i_head.hold_wr && out_free;
        rel_now  = r_rel_idx < i_head.rel_cnt;
        smp_now  = !rel_now && i_head.smp_v && !r_smp_done;
        if (rel_now) begin
            kind = KIND_SAMPLE;
            data = {40'd0, r_hold[r_rel_idx]};
            last = (r_rel_idx == i_head.rel_cnt - HOLD_AW'(1)) &&
                   !i_head.smp_v && !i_head.st_v;
        end else if (smp_now) begin
            kind = KIND_SAMPLE;
            data = {40'd0, i_head.smp};
            last = !i_head.st_v;
        end else begin
            kind = KIND_STATUS;
            data = {7'd0, i_head.total, i_head.status, 16'd0};
            last = 1'b1;
        end
        o_pop = wr_job || (emit && last);
    end

    always_ff @(posedge i_clk) begin
        if (wr_job) begin
            r_hold[i_head.hold_addr] <= i_head.smp;
        end
        if (emit) begin
            r_out_data <= data;
            r_out_kind <= kind;
            r_out_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_idx   <= '0;
            r_smp_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (last) begin
                    r_rel_idx  <= '0;
                    r_smp_done <= 1'b0;
                end else if (rel_now) begin
                    r_rel_idx <= r_rel_idx + HOLD_AW'(1);
                end else begin
                    r_smp_done <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_kind  = r_out_kind;
    assign o_last  = r_out_last;

endmodule

@@ tb/wav_data_chunk_extractor_test.sv @@
// Testbench for the WAV data chunk extractor: byte stream in, checked sample and status words out.
`timescale 1ns / 100ps

module wav_data_chunk_extractor_test import wdce_pkg::*;;

    typedef struct packed {
        logic        kind;
        logic [15:0] pcm;
        logic [1:0]  status;
        logic [30:0] total;
        logic        last;
    } t_result_word;

    // Mirror of the parser plus the words still owed by the block
    class wav_scoreboard;
        logic [2:0]   phase;
        logic [31:0]  pos;
        logic [31:0]  tag_sr;
        logic [31:0]  size_sr;
        logic [32:0]  skip_left;
        logic [31:0]  data_left;
        logic [8:0]   low_byte;
        logic [15:0]  held [HOLD_DEPTH];
        int           held_n;
        logic [30:0]  sent_total;
        t_result_word expected_words[$];
        int           errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase      = PH_HEADER;
            pos        = '0;
            tag_sr     = '0;
            size_sr    = '0;
            skip_left  = '0;
            data_left  = '0;
            low_byte   = '0;
            held_n     = 0;
            sent_total = '0;
            foreach (held[i]) held[i] = '0;
        endfunction

        function void push_result(logic kind, logic [15:0] pcm, logic [1:0] status,
                                  logic [30:0] total);
            t_result_word w;
            w.kind   = kind;
            w.pcm    = pcm;
            w.status = status;
            w.total  = total;
            w.last   = 1'b0;
            expected_words.push_back(w);
        endfunction

        function void deliver(logic [15:0] pcm);
            push_result(KIND_SAMPLE, pcm, ST_OK, '0);
            if (sent_total != COUNT_MAX)
                sent_total++;
        endfunction

        // one accepted byte: work out every word it causes
        function void note_byte(logic [7:0] b, logic eof);
            logic [31:0]  p;
            logic [15:0]  s;
            logic [1:0]   st;
            int           n_before;
            t_result_word w;
            p = pos;
            n_before = expected_words.size();

            if (p == RELEASE_POS && phase != PH_BAD) begin
                for (int i = 0; i < held_n; i++)
                    deliver(held[i]);
                held_n = 0;
            end

            case (phase)
                PH_HEADER: begin
                    tag_sr = {tag_sr[23:0], b};
                    if (p == RIFF_END_POS && tag_sr != TAG_RIFF) begin
                        phase = PH_BAD;
                    end else if (p == WAVE_END_POS) begin
                        if (tag_sr != TAG_WAVE) begin
                            phase = PH_BAD;
                        end else begin
                            phase = PH_CHUNK_HDR;
                            skip_left = CHUNK_HDR_LEN;
                        end
                    end
                end
                PH_CHUNK_HDR: begin
                    if (skip_left > TAG_BYTES_LEFT)
                        tag_sr = {tag_sr[23:0], b};
                    else
                        size_sr = {b, size_sr[31:8]};
                    if (skip_left != 0)
                        skip_left--;
                    // a header finished on the final byte is never looked at
                    if (skip_left == 0 && !eof) begin
                        if (tag_sr == TAG_DATA) begin
                            data_left = size_sr;
                            low_byte  = '0;
                            phase = (size_sr != 0) ? PH_DATA : PH_DONE;
                        end else begin
                            skip_left = {1'b0, size_sr} + size_sr[0];
                            if (skip_left == 0)
                                skip_left = CHUNK_HDR_LEN;
                            else
                                phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_left != 0)
                        skip_left--;
                    if (skip_left == 0) begin
                        phase = PH_CHUNK_HDR;
                        skip_left = CHUNK_HDR_LEN;
                    end
                end
                PH_DATA: begin
                    if (low_byte[8]) begin
                        s = {b, low_byte[7:0]};
                        low_byte = '0;
                        if (p < RELEASE_POS) begin
                            if (held_n < HOLD_DEPTH) begin
                                held[held_n] = s;
                                held_n++;
                            end
                        end else begin
                            deliver(s);
                        end
                    end else begin
                        low_byte = {1'b1, b};
                    end
                    if (data_left != 0)
                        data_left--;
                    if (data_left == 0) begin
                        phase = PH_DONE;
                        low_byte = '0;
                    end
                end
                default: ;
            endcase

            if (p != '1)
                pos = p + 1;

            if (eof) begin
                if (p < RELEASE_POS || phase == PH_BAD)
                    st = ST_INVALID;
                else if (phase == PH_DATA || phase == PH_DONE)
                    st = ST_OK;
                else
                    st = ST_NO_DATA;
                push_result(KIND_STATUS, '0, st, (st == ST_INVALID) ? '0 : sent_total);
                clear();
            end

            if (expected_words.size() > n_before) begin
                w = expected_words.pop_back();
                w.last = 1'b1;
                expected_words.push_back(w);
            end
        endfunction

        task report_mismatch(string field, longint got, longint want);
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
            errors++;
        endtask

        task check_word(logic kind, logic [15:0] pcm, logic [1:0] status, logic [30:0] total,
                        logic last);
            t_result_word want;
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", {kind, status, pcm}, 0);
                return;
            end
            want = expected_words.pop_front();
            if (kind !== want.kind)     report_mismatch("result_kind", kind, want.kind);
            if (pcm !== want.pcm)       report_mismatch("pcm_sample", pcm, want.pcm);
            if (status !== want.status) report_mismatch("parse_status", status, want.status);
            if (total !== want.total)   report_mismatch("sample_total", total, want.total);
            if (last !== want.last)     report_mismatch("run_last", last, want.last);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // [7:0] file_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;           // [15:0] pcm_sample, [17:16] parse_status,
                                         // [48:18] sample_total, [55:49] zero
    logic        m_axis_tuser;           // [0] result_kind
    logic        m_axis_tlast;

    wav_scoreboard sb;
    logic [7:0]    file_bytes[$];

    int   hold_left    = 0;
    int   run_left     = 0;
    int   recv_roll;
    logic ready_level  = 1'b1;
    bit   hold_off_req = 1'b0;

    wav_data_chunk_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: checks each word taken, then picks tready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[17:16],
                          m_axis_tdata[48:18], m_axis_tlast);
        if (hold_off_req) begin
            hold_left = 120;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            if (run_left == 0) begin
                recv_roll = $urandom_range(0, 99);
                if (recv_roll < 50) begin
                    ready_level = 1'b1;
                    run_left = $urandom_range(1, 8);
                end else if (recv_roll < 60) begin
                    ready_level = 1'b1;
                    run_left = $urandom_range(40, 150);
                end else if (recv_roll < 90) begin
                    ready_level = 1'b0;
                    run_left = $urandom_range(1, 3);
                end else begin
                    ready_level = 1'b0;
                    run_left = $urandom_range(8, 25);
                end
            end
            m_axis_tready <= ready_level;
            run_left--;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function void put_tag(logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(tag[8*i +: 8]);
    endfunction

    function void put_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function void put_random(int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function void put_header();
        put_tag(TAG_RIFF);
        put_le32($urandom());
        put_tag(TAG_WAVE);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, last);
    endtask

    task automatic send_file(input bit no_gaps);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1, no_gaps);
    endtask

    // the sender goes idle and waits for every owed word
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_words.size() != 0);
    endtask

    // mostly well-formed files with random content; some noise and broken magic
    task automatic build_random_file();
        int          r;
        int          n;
        int          idx;
        int          len;
        logic [31:0] tag;
        logic [31:0] size;
        file_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 12) begin
            put_random($urandom_range(1, 60));
            return;
        end
        put_header();
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            tag = $urandom();
            if (tag == TAG_DATA)
                tag = ~tag;
            size = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 12);
            put_tag(tag);
            put_le32(size);
            put_random(size > 40 ? 40 : size + size[0]);
        end
        size = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 40);
        put_tag(TAG_DATA);
        put_le32(size);
        put_random((size > 40 ? 40 : size) + $urandom_range(0, 6));
        if (r < 22) begin
            idx = $urandom_range(0, 7);
            if (idx > 3)
                idx += 4;
            file_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > len)
                void'(file_bytes.pop_back());
        end
    endtask

    initial begin
        int random_bytes;
        bit steady;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data chunk right at byte 12, ends on byte 43: eleven held samples,
        // one live sample and the status all come from the final byte
        file_bytes.delete();
        put_header();
        put_tag(TAG_DATA);
        put_le32(32'd24);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h80);
        file_bytes.push_back(8'hff); file_bytes.push_back(8'h7f);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hff); file_bytes.push_back(8'hff);
        put_random(16);
        send_file(1'b0);

        // one-byte file
        file_bytes.delete();
        file_bytes.push_back(8'h52);
        send_file(1'b0);

        // bad RIFF magic, short
        file_bytes.delete();
        put_tag(TAG_RIFF ^ 32'h1);
        send_file(1'b0);

        // bad WAVE magic, long enough, with a data chunk that must be ignored
        file_bytes.delete();
        put_tag(TAG_RIFF);
        put_random(4);
        put_tag(TAG_WAVE ^ 32'h0100_0000);
        put_tag(TAG_DATA);
        put_le32(32'd28);
        put_random(24);
        send_file(1'b0);

        // under 44 bytes: held samples are dropped
        file_bytes.delete();
        put_header();
        put_tag(TAG_DATA);
        put_le32(32'd100);
        put_random(4);
        send_file(1'b0);

        // odd chunk with pad, then truncated data ending on a lone low byte;
        // receiver holds off so the block backs up into its input
        wait_drained();
        hold_off_req = 1'b1;
        file_bytes.delete();
        put_header();
        put_tag("fmt ");
        put_le32(32'd5);
        put_random(6);
        put_tag(TAG_DATA);
        put_le32(32'd200);
        put_random(21);
        send_file(1'b1);

        // empty chunk, empty data chunk, then a second data chunk that is ignored
        file_bytes.delete();
        put_header();
        put_tag("LIST");
        put_le32(32'd0);
        put_tag(TAG_DATA);
        put_le32(32'd0);
        put_tag(TAG_DATA);
        put_le32(32'd4);
        put_random(8);
        send_file(1'b0);

        // data chunk header whose last byte ends the file
        file_bytes.delete();
        put_header();
        put_tag("junk");
        put_le32(32'd16);
        put_random(16);
        put_tag(TAG_DATA);
        put_le32(32'd4);
        send_file(1'b0);

        // largest odd size: skip count must not wrap
        file_bytes.delete();
        put_header();
        put_tag("junk");
        put_le32(32'hffff_ffff);
        put_random(24);
        send_file(1'b0);

        // sender pauses until the block has nothing left to give
        wait_drained();

        random_bytes = 0;
        while (random_bytes < 30) begin
            build_random_file();
            steady = ($urandom_range(0, 3) == 0);
            send_file(steady);
            random_bytes += file_bytes.size();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
